[design/ppzb_pkg.sv]
`timescale 1ns / 1ps
package ppzb_pkg;

   // default geometry and window
   localparam int IMAGE_W_DEF      = 1024;
   localparam int IMAGE_H_DEF      = 1024;
   localparam int MAX_POINTS_DEF   = 4096;
   localparam int QUEUE_FRAMES_DEF = 3;

   // fixed field widths
   localparam int COORD_W   = 32;
   localparam int PIX_W     = 10;
   localparam int DEPTH_W   = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   // accumulator for one dot product: three 48-bit terms and an offset
   localparam int ACC_W = 50;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_ROW0_LO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_ROW0_HI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_ROW1_LO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_ROW1_HI = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_ROW_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_ROW_HI = 3'd5;
   localparam int CFG_COUNT = 6;

   // command codes
   localparam logic CMD_PROJECT = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic                      first_of_frame;
      logic [PIX_W-1:0]          read_col;
      logic [PIX_W-1:0]          read_row;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_col;
      logic [PIX_W-1:0]   pixel_row;
      logic [DEPTH_W-1:0] depth_value;
      logic               depth_written;
      logic               frame_stopped;
      logic               frame_overflow;
   } rsp_payload_type;

endpackage

[design/ppzb_ram.sv]
`timescale 1ns / 1ps
module ppzb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[design/ppzb_div.sv]
`timescale 1ns / 1ps
module ppzb_div #(
   parameter int NUM_W = 50,
   parameter int QW    = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [NUM_W-1:0] den,
   output logic                    done,
   output logic [QW-1:0]           quot
);
   typedef enum logic [1:0] {D_IDLE, D_PRE, D_ITER} div_state_type;

   localparam int EXT_W = NUM_W + QW;
   localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

   div_state_type     state_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [EXT_W-1:0]  dsh_ff;
   logic [QW-1:0]     q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              done_ff;
   logic [QW-1:0]     quot_ff;

   logic [NUM_W-1:0]  num_mag;
   logic [NUM_W-1:0]  den_mag;
   logic              zero_q;
   logic [EXT_W-1:0]  rem_ext;
   logic              ge;

   // magnitudes; a quotient of mixed signs is never a positive pixel
   assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
   assign zero_q  = (num == '0) || (den == '0) || (num[NUM_W-1] ^ den[NUM_W-1]);
   assign rem_ext = {{QW{1'b0}}, rem_ff};
   assign ge      = rem_ext >= dsh_ff;

   // restoring divide, one quotient bit a cycle, after a range pre-check
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  rem_ff <= num_mag;
                  dsh_ff <= {den_mag, {QW{1'b0}}};
                  q_ff   <= '0;
                  if (zero_q) begin
                     done_ff <= 1'b1;
                     quot_ff <= '0;
                  end else begin
                     state_ff <= D_PRE;
                  end
               end
            end
            D_PRE: begin
               if (ge) begin
                  done_ff  <= 1'b1;
                  quot_ff  <= '0;
                  state_ff <= D_IDLE;
               end else begin
                  dsh_ff   <= dsh_ff >> 1;
                  cnt_ff   <= '0;
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               if (ge) begin
                  rem_ff <= rem_ff - dsh_ff[NUM_W-1:0];
               end
               q_ff   <= {q_ff[QW-2:0], ge};
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(QW - 1)) begin
                  done_ff  <= 1'b1;
                  quot_ff  <= {q_ff[QW-2:0], ge};
                  state_ff <= D_IDLE;
               end
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

[design/point_projection_zbuffer_window_top.sv]
`timescale 1ns / 1ps
// Projects Q16.16 points through a 3x4 camera matrix into a z-buffer held in a
// single-port-write memory of IMAGE_W*IMAGE_H depth words, and keeps the pixels
// of the last QUEUE_FRAMES frames in a second memory so the oldest frame can be
// erased when a new one opens. After reset the block clears the depth memory,
// one word a cycle, before it takes the first item. A read item passes through
// the states S_RD, S_RD2 and S_DONE before its result is registered. A project
// item forms nine products on one shared 32x32 multiplier, then two quotients
// from one shared bit-serial divider, then records the pixel and, while writes
// are open, does the depth read-modify-write. An item that opens a frame while
// the window is full first walks the evicted frame (the eviction walk reads the
// pixel store and zeroes the depth memory in step). One item is in flight at a
// time; the next is accepted while a result waits.
module point_projection_zbuffer_window_top #(
   parameter int IMAGE_W      = ppzb_pkg::IMAGE_W_DEF,
   parameter int IMAGE_H      = ppzb_pkg::IMAGE_H_DEF,
   parameter int MAX_POINTS   = ppzb_pkg::MAX_POINTS_DEF,
   parameter int QUEUE_FRAMES = ppzb_pkg::QUEUE_FRAMES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ppzb_pkg::req_payload_type          req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ppzb_pkg::rsp_payload_type          rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppzb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppzb_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ppzb_pkg::*;

   localparam int CBW      = $clog2(IMAGE_W);
   localparam int RBW      = $clog2(IMAGE_H);
   localparam int QW       = (CBW > RBW) ? CBW : RBW;
   localparam int DM_DEPTH = IMAGE_W * IMAGE_H;
   localparam int DAW      = $clog2(DM_DEPTH);
   localparam int REC_W    = RBW + CBW;
   localparam int REC_DEPTH = QUEUE_FRAMES * MAX_POINTS;
   localparam int RAW      = $clog2(REC_DEPTH);
   localparam int IW       = $clog2(MAX_POINTS);
   localparam int PW       = $clog2(MAX_POINTS + 1);
   localparam int SW       = (QUEUE_FRAMES > 1) ? $clog2(QUEUE_FRAMES) : 1;
   localparam int HW       = $clog2(QUEUE_FRAMES + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_RD2, S_OPEN, S_EVICT, S_MUL, S_MULEND,
      S_DCHK, S_DIVU_GO, S_DIVU_W, S_DIVV_GO, S_DIVV_W, S_REC, S_ZC, S_DONE
   } state_type;

   state_type                 state_ff;
   logic [CSR_DATA_W-1:0]     cfg_ff [CFG_COUNT];
   logic [DAW-1:0]            clr_ff;

   // item registers
   logic                      cmd_ff;
   logic                      fof_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic [PIX_W-1:0]          rdcol_ff, rdrow_ff;
   logic                      rd_inrange_ff;
   logic [CBW-1:0]            col_ff;
   logic [RBW-1:0]            row_ff;
   logic [DEPTH_W-1:0]        dv_ff;
   logic                      wrote_ff;
   logic                      ovf_ff;

   // frame window state
   logic [PW-1:0]             cnt_ff [QUEUE_FRAMES];
   logic [HW-1:0]             held_ff;
   logic [SW-1:0]             slot_ff;
   logic [PW-1:0]             ptf_ff;
   logic                      stopped_ff;

   // eviction walk
   logic [SW-1:0]             ev_slot_ff;
   logic [PW-1:0]             ev_n_ff;
   logic [PW-1:0]             ev_i_ff;
   logic                      ev_pend_ff;

   // multiply-accumulate
   logic [1:0]                mr_ff, mt_ff;
   logic signed [2*COORD_W-1:0] prod_ff;
   logic [1:0]                prod_row_ff;
   logic                      prod_vld_ff;
   logic signed [ACC_W-1:0]   acc_ff [3];

   // output register
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_payload_ff;

   // memory ports
   logic                      dm_we;
   logic [DAW-1:0]            dm_waddr, dm_raddr;
   logic [DEPTH_W-1:0]        dm_wdata, dm_rdata;
   logic                      rec_we;
   logic [RAW-1:0]            rec_waddr, rec_raddr;
   logic [REC_W-1:0]          rec_wdata, rec_rdata;

   // combinational helpers
   logic                      div_start;
   logic signed [ACC_W-1:0]   div_num;
   logic                      div_done;
   logic [QW-1:0]             div_quot;
   logic [CSR_DATA_W-1:0]     lo_word, hi_word;
   logic signed [COORD_W-1:0] coef, opnd;
   logic signed [2*COORD_W-1:0] prod_shift;
   logic signed [ACC_W-1:0]   depth_acc;
   logic                      z_write;
   logic [SW-1:0]             next_slot;
   logic [15:0]               col_wide, row_wide;

   function automatic logic [DAW-1:0] pix_addr(logic [RBW-1:0] r, logic [CBW-1:0] c);
      return DAW'(r * IMAGE_W + c);
   endfunction

   function automatic logic [RAW-1:0] rec_addr(logic [SW-1:0] s, logic [IW-1:0] i);
      return RAW'(s * MAX_POINTS + i);
   endfunction

   function automatic logic signed [ACC_W-1:0] sext32(logic [COORD_W-1:0] w);
      return {{(ACC_W-COORD_W){w[COORD_W-1]}}, w};
   endfunction

   // coefficient and operand of the current product
   assign lo_word = cfg_ff[{mr_ff, 1'b0}];
   assign hi_word = cfg_ff[{mr_ff, 1'b1}];
   always_comb begin
      case (mt_ff)
         2'd0:    begin coef = lo_word[31:0];  opnd = px_ff; end
         2'd1:    begin coef = lo_word[63:32]; opnd = py_ff; end
         default: begin coef = hi_word[31:0];  opnd = pz_ff; end
      endcase
   end
   assign prod_shift = prod_ff >>> 16;
   assign depth_acc  = acc_ff[2];

   assign next_slot = (slot_ff == SW'(QUEUE_FRAMES - 1)) ? '0 : slot_ff + 1'b1;

   // z test: empty pixel or nearer point
   assign z_write = (dm_rdata == '0) || (dv_ff < dm_rdata);

   // depth memory ports
   always_comb begin
      dm_we    = 1'b0;
      dm_waddr = pix_addr(row_ff, col_ff);
      dm_wdata = '0;
      if (state_ff == S_CLEAR) begin
         dm_we    = 1'b1;
         dm_waddr = clr_ff;
      end else if (ev_pend_ff) begin
         dm_we    = 1'b1;
         dm_waddr = pix_addr(rec_rdata[REC_W-1:CBW], rec_rdata[CBW-1:0]);
      end else if (state_ff == S_ZC && z_write) begin
         dm_we    = 1'b1;
         dm_wdata = dv_ff;
      end
   end
   assign dm_raddr = pix_addr(row_ff, col_ff);

   // pixel store ports
   assign rec_we    = (state_ff == S_REC) && (ptf_ff < PW'(MAX_POINTS));
   assign rec_waddr = rec_addr(slot_ff, ptf_ff[IW-1:0]);
   assign rec_wdata = {row_ff, col_ff};
   assign rec_raddr = rec_addr(ev_slot_ff, ev_i_ff[IW-1:0]);

   assign div_start = (state_ff == S_DIVU_GO) || (state_ff == S_DIVV_GO);
   assign div_num   = (state_ff == S_DIVV_GO) ? acc_ff[1] : acc_ff[0];

   ppzb_ram #(.WIDTH(DEPTH_W), .DEPTH(DM_DEPTH)) u_depth_ram (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (dm_raddr),
      .rd_data (dm_rdata)
   );

   ppzb_ram #(.WIDTH(REC_W), .DEPTH(REC_DEPTH)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (rec_waddr),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   ppzb_div #(.NUM_W(ACC_W), .QW(QW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (depth_acc),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer, item registers and output register
   always_ff @(posedge clock) begin
      prod_vld_ff <= 1'b0;
      ev_pend_ff  <= 1'b0;
      if (prod_vld_ff) begin
         acc_ff[prod_row_ff] <= acc_ff[prod_row_ff] + prod_shift[ACC_W-1:0];
      end
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         held_ff      <= '0;
         slot_ff      <= '0;
         ptf_ff       <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CFG_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
         for (int i = 0; i < QUEUE_FRAMES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && (32'(csr_index) < CFG_COUNT)) begin
            cfg_ff[csr_index] <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == DAW'(DM_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_payload.cmd;
                  fof_ff   <= req_payload.first_of_frame;
                  px_ff    <= req_payload.point_x;
                  py_ff    <= req_payload.point_y;
                  pz_ff    <= req_payload.point_z;
                  rdcol_ff <= req_payload.read_col;
                  rdrow_ff <= req_payload.read_row;
                  rd_inrange_ff <= (32'(req_payload.read_col) < IMAGE_W) &&
                                   (32'(req_payload.read_row) < IMAGE_H);
                  col_ff   <= CBW'(req_payload.read_col);
                  row_ff   <= RBW'(req_payload.read_row);
                  wrote_ff <= 1'b0;
                  ovf_ff   <= 1'b0;
                  dv_ff    <= '0;
                  for (int r = 0; r < 3; r++) begin
                     acc_ff[r] <= sext32(cfg_ff[2*r+1][63:32]);
                  end
                  state_ff <= (req_payload.cmd == CMD_READ) ? S_RD : S_OPEN;
               end
            end
            S_RD: begin
               state_ff <= S_RD2;
            end
            S_RD2: begin
               dv_ff    <= rd_inrange_ff ? dm_rdata : '0;
               state_ff <= S_DONE;
            end
            S_OPEN: begin
               mr_ff    <= '0;
               mt_ff    <= '0;
               state_ff <= S_MUL;
               if (fof_ff || (held_ff == '0)) begin
                  ptf_ff     <= '0;
                  stopped_ff <= 1'b0;
                  if (held_ff == '0) begin
                     held_ff   <= HW'(1);
                     slot_ff   <= '0;
                     cnt_ff[0] <= '0;
                  end else begin
                     slot_ff           <= next_slot;
                     cnt_ff[next_slot] <= '0;
                     if (32'(held_ff) >= QUEUE_FRAMES) begin
                        ev_slot_ff <= next_slot;
                        ev_n_ff    <= cnt_ff[next_slot];
                        ev_i_ff    <= '0;
                        state_ff   <= S_EVICT;
                     end else begin
                        held_ff <= held_ff + 1'b1;
                     end
                  end
               end
            end
            S_EVICT: begin
               // read one recorded pixel a cycle, zero it the cycle after
               if (ev_i_ff < ev_n_ff) begin
                  ev_i_ff    <= ev_i_ff + 1'b1;
                  ev_pend_ff <= 1'b1;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff     <= coef * opnd;
               prod_row_ff <= mr_ff;
               prod_vld_ff <= 1'b1;
               if (mt_ff == 2'd2) begin
                  mt_ff <= '0;
                  mr_ff <= mr_ff + 1'b1;
                  if (mr_ff == 2'd2) begin
                     state_ff <= S_MULEND;
                  end
               end else begin
                  mt_ff <= mt_ff + 1'b1;
               end
            end
            S_MULEND: begin
               state_ff <= S_DCHK;
            end
            S_DCHK: begin
               if (!depth_acc[ACC_W-1] && (depth_acc != '0)) begin
                  dv_ff <= (depth_acc[ACC_W-2:DEPTH_W] != '0) ? '1
                                                              : depth_acc[DEPTH_W-1:0];
               end else begin
                  dv_ff <= '0;
               end
               if (depth_acc == '0) begin
                  col_ff   <= '0;
                  row_ff   <= '0;
                  state_ff <= S_REC;
               end else begin
                  state_ff <= S_DIVU_GO;
               end
            end
            S_DIVU_GO: begin
               state_ff <= S_DIVU_W;
            end
            S_DIVU_W: begin
               if (div_done) begin
                  col_ff   <= (32'(div_quot) < IMAGE_W) ? CBW'(div_quot) : '0;
                  state_ff <= S_DIVV_GO;
               end
            end
            S_DIVV_GO: begin
               state_ff <= S_DIVV_W;
            end
            S_DIVV_W: begin
               if (div_done) begin
                  row_ff   <= (32'(div_quot) < IMAGE_H) ? RBW'(div_quot) : '0;
                  state_ff <= S_REC;
               end
            end
            S_REC: begin
               // record the pixel unless the frame is full, then test the z-buffer if writes are open
               if (ptf_ff >= PW'(MAX_POINTS)) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  ptf_ff          <= ptf_ff + 1'b1;
                  cnt_ff[slot_ff] <= ptf_ff + 1'b1;
                  if (depth_acc[ACC_W-1] || (depth_acc == '0)) begin
                     stopped_ff <= 1'b1;
                     state_ff   <= S_DONE;
                  end else if (!stopped_ff) begin
                     state_ff <= S_ZC;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_ZC: begin
               wrote_ff <= z_write;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff                  <= 1'b1;
                  rsp_payload_ff.pixel_col      <= (cmd_ff == CMD_READ) ? rdcol_ff
                                                                        : col_wide[PIX_W-1:0];
                  rsp_payload_ff.pixel_row      <= (cmd_ff == CMD_READ) ? rdrow_ff
                                                                        : row_wide[PIX_W-1:0];
                  rsp_payload_ff.depth_value    <= dv_ff;
                  rsp_payload_ff.depth_written  <= wrote_ff;
                  rsp_payload_ff.frame_stopped  <= stopped_ff;
                  rsp_payload_ff.frame_overflow <= ovf_ff;
                  state_ff                      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign col_wide = 16'(col_ff);
   assign row_wide = 16'(row_ff);

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;
endmodule
